// File: src/olad_pkg.sv
// Package with the shared constants, types and codes of the ordered list core.
`default_nettype none
package olad_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELETE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic append;
    logic load_match;
    logic del_commit;
    logic empty_rsp;
    logic dump_load;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic dump_last;
  } sts_t;

endpackage
`default_nettype wire

// File: src/ordered_list_append_delete_core.sv
// Top level of the ordered list core: appends, deletes by value and dumps a list of words.
//
// A command word (kind, value) is taken at a rising edge where start is high and busy is
// low. Every result word is shown on status, entry and last for exactly one cycle with
// strobe high; the receiver takes it at the edge that ends that cycle and cannot stall.
// An append gives one result in the cycle after it is taken and leaves busy low, so
// appends may follow one another every cycle. A delete compares all cells in the cycle
// of acceptance, shifts the cells behind the first match in the next, and gives its one
// result in the cycle after the shift, while busy is high only during the shift. A dump of
// N entries gives N results on consecutive cycles by rotating the list through cell zero;
// busy stays high while the dump steps run. A dump of an empty list gives one result.
// The unused kind code is dropped without a result.
// Reset clears the entry count and the controller; cell contents need no clearing.
`default_nettype none
module ordered_list_append_delete_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind,
  input  logic signed [olad_pkg::VAL_W-1:0] value,
  output logic                              strobe,
  output logic [1:0]                        status,
  output logic signed [olad_pkg::VAL_W-1:0] entry,
  output logic                              last
);
  import olad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  olad_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (value),
    .sts    (sts),
    .strobe (strobe),
    .status (status),
    .entry  (entry),
    .last   (last)
  );

endmodule
`default_nettype wire

// File: src/olad_ctrl.sv
// Controller state machine of the ordered list core.
`default_nettype none
module olad_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    kind,
  input  olad_pkg::sts_t sts,
  output olad_pkg::cmd_t cmd,
  output logic          busy
);
  import olad_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && kind == KIND_DELETE) begin
          state_next = ST_DELETE;
        end else if (start && kind == KIND_DUMP && !sts.count_zero) begin
          state_next = ST_DUMP;
        end
      end
      ST_DELETE: begin
        state_next = ST_IDLE;
      end
      ST_DUMP: begin
        if (sts.dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (kind)
            KIND_APPEND: cmd.append = 1'b1;
            KIND_DELETE: cmd.load_match = 1'b1;
            KIND_DUMP: begin
              if (sts.count_zero) begin
                cmd.empty_rsp = 1'b1;
              end else begin
                cmd.dump_load = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_DELETE: begin
        cmd.del_commit = 1'b1;
      end
      ST_DUMP: begin
        cmd.dump_step = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/olad_datapath.sv
// Datapath of the ordered list core: list cells, match vector, count and result register.
`default_nettype none
module olad_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  olad_pkg::cmd_t                cmd,
  input  logic signed [olad_pkg::VAL_W-1:0] value,
  output olad_pkg::sts_t                sts,
  output logic                          strobe,
  output logic [1:0]                    status,
  output logic signed [olad_pkg::VAL_W-1:0] entry,
  output logic                          last
);
  import olad_pkg::*;

  logic [VAL_W-1:0] cells [DEPTH];
  logic [DEPTH-1:0] matchv;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] shift_mask;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remain;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             found;

  assign full     = (count == CNT_W'(DEPTH));
  assign tail_idx = count[IDX_W-1:0];
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign found    = |matchv;

  assign sts.count_zero = (count == '0);
  assign sts.dump_last  = (remain == CNT_W'(1));

  always_comb begin
    shift_mask = matchv;
    for (int k = 0; k < IDX_W; k++) begin
      shift_mask = shift_mask | (shift_mask << (1 << k));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign valid[g] = (CNT_W'(g) < count);

    always_ff @(posedge clk) begin
      if (cmd.append && !full && tail_idx == IDX_W'(g)) begin
        cells[g] <= value;
      end else if (cmd.dump_step && last_idx == IDX_W'(g)) begin
        cells[g] <= cells[0];
      end else if (g < DEPTH - 1) begin
        if ((cmd.dump_step && valid[g]) ||
            (cmd.del_commit && shift_mask[g] && valid[g])) begin
          cells[g] <= cells[(g + 1) % DEPTH];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load_match) begin
        matchv[g] <= (cells[g] == value) && valid[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.del_commit && found) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (cmd.dump_load) begin
      remain <= count;
    end else if (cmd.dump_step) begin
      remain <= remain - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.append | cmd.del_commit | cmd.empty_rsp | cmd.dump_step;
    end
  end

  always_ff @(posedge clk) begin
    entry <= '0;
    last  <= 1'b1;
    priority if (cmd.append) begin
      status <= full ? STATUS_FULL : STATUS_OK;
    end else if (cmd.del_commit) begin
      status <= found ? STATUS_OK : STATUS_NOTFOUND;
    end else if (cmd.empty_rsp) begin
      status <= STATUS_EMPTY;
    end else begin
      status <= STATUS_OK;
      entry  <= cells[0];
      last   <= (remain == CNT_W'(1));
    end
  end

endmodule
`default_nettype wire

// File: test/tb_ordered_list_append_delete_core.sv
// Self-checking testbench of the ordered list core with a mirrored list and a result scoreboard.
module tb_ordered_list_append_delete_core;
  timeunit 1ns;
  timeprecision 1ps;

  import olad_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry;
    logic                    last;
  } result_word_t;

  class list_result_board;
    logic signed [VAL_W-1:0] cells[$];
    result_word_t            expected_words[$];
    int                      failures;

    function new();
      failures = 0;
    endfunction

    function void push_word(logic [1:0] st, logic signed [VAL_W-1:0] ent, logic lst);
      result_word_t w;
      w.status = st;
      w.entry  = ent;
      w.last   = lst;
      expected_words.push_back(w);
    endfunction

    function void note_command(logic [1:0] k, logic signed [VAL_W-1:0] v);
      int hit;
      hit = -1;
      case (k)
        KIND_APPEND: begin
          if (cells.size() >= DEPTH) begin
            push_word(STATUS_FULL, '0, 1'b1);
          end else begin
            cells.push_back(v);
            push_word(STATUS_OK, '0, 1'b1);
          end
        end
        KIND_DELETE: begin
          for (int i = 0; i < cells.size(); i++) begin
            if (hit < 0 && cells[i] == v) hit = i;
          end
          if (hit < 0) begin
            push_word(STATUS_NOTFOUND, '0, 1'b1);
          end else begin
            cells.delete(hit);
            push_word(STATUS_OK, '0, 1'b1);
          end
        end
        KIND_DUMP: begin
          if (cells.size() == 0) begin
            push_word(STATUS_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < cells.size(); i++)
              push_word(STATUS_OK, cells[i], (i == cells.size() - 1));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic signed [VAL_W-1:0] ent, logic lst);
      result_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d, entry %0d, last %0b", st, ent, lst);
        failures++;
        return;
      end
      w = expected_words.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, st);
        failures++;
      end
      if (ent !== w.entry) begin
        $error("entry: expected %0d, actual %0d", w.entry, ent);
        failures++;
      end
      if (lst !== w.last) begin
        $error("last: expected %0b, actual %0b", w.last, lst);
        failures++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              kind;
  logic signed [VAL_W-1:0] value;
  logic                    strobe;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] entry;
  logic                    last;

  list_result_board board = new();
  int sender_idle_pct = 0;

  ordered_list_append_delete_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .kind   (kind),
    .value  (value),
    .strobe (strobe),
    .status (status),
    .entry  (entry),
    .last   (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe !== 1'b0) board.check_result(status, entry, last);
      if (start === 1'b1 && busy === 1'b0) board.note_command(kind, value);
    end
  end

  task automatic send_word(input logic [1:0] k, input logic signed [VAL_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(logic for_delete);
    int r;
    r = $urandom_range(0, 99);
    if (for_delete && board.cells.size() > 0 && r < 70)
      return board.cells[$urandom_range(0, board.cells.size() - 1)];
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 15);
    if (r < 45) return VAL_MIN;
    if (r < 50) return VAL_MAX;
    if (r < 55) return -1;
    return $urandom;
  endfunction

  task automatic run_random(input int items, input int append_pct);
    int done;
    int r;
    logic [1:0] k;
    done = 0;
    while (done < items) begin
      r = $urandom_range(0, 99);
      if (r < append_pct) k = KIND_APPEND;
      else if (r < 89) k = KIND_DELETE;
      else if (r < 97) k = KIND_DUMP;
      else k = KIND_UNUSED;
      send_word(k, pick_value(k == KIND_DELETE));
      if (k != KIND_UNUSED) done++;
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    kind  = KIND_APPEND;
    value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(KIND_DUMP, VAL_MAX);
    send_word(KIND_DELETE, 0);
    send_word(KIND_APPEND, VAL_MIN);
    send_word(KIND_APPEND, VAL_MAX);
    send_word(KIND_APPEND, 5);
    send_word(KIND_APPEND, -1);
    send_word(KIND_APPEND, 5);
    send_word(KIND_APPEND, 0);
    send_word(KIND_DUMP, 0);
    send_word(KIND_DELETE, 5);
    send_word(KIND_DUMP, -1);
    send_word(KIND_DELETE, 99);
    send_word(KIND_UNUSED, VAL_MIN);
    send_word(KIND_DELETE, VAL_MIN);
    send_word(KIND_DELETE, 0);
    send_word(KIND_DELETE, VAL_MAX);
    send_word(KIND_DUMP, 0);
    send_word(KIND_DELETE, -1);
    send_word(KIND_DELETE, 5);
    send_word(KIND_DUMP, VAL_MIN);
    drain_results();

    sender_idle_pct = 0;
    run_random(120, 80);
    drain_results();
    sender_idle_pct = 83;
    run_random(120, 45);
    drain_results();
    sender_idle_pct = 0;
    run_random(120, 25);
    drain_results();
    sender_idle_pct = 37;
    run_random(120, 55);
    drain_results();

    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: ordered_list_append_delete_core.f
src/olad_pkg.sv
src/olad_ctrl.sv
src/olad_datapath.sv
src/ordered_list_append_delete_core.sv
test/tb_ordered_list_append_delete_core.sv
